### hw/rtl/mf_pkg.sv
// Shared types and constants for the median finder.
package mf_pkg;

	localparam int DATA_W         = 32;
	localparam int SIZE_W         = 8;
	localparam int MAX_VALUES_DEF = 128;

	typedef struct packed {
		logic signed [DATA_W-1:0] sample;
		logic                     last_item;
	} mf_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] median_value;
		logic [SIZE_W-1:0]        set_size;
		logic                     overflowed;
	} mf_res_t;

	// Broadcast control for the cell row.
	typedef struct packed {
		logic                     ins;      // insert ins_val in sorted place
		logic                     shl;      // every cell takes its right neighbor
		logic signed [DATA_W-1:0] ins_val;
	} mf_cell_ctl_t;

	typedef enum logic {
		MF_IDLE,
		MF_DRAIN
	} mf_state_t;

endpackage

### hw/rtl/mf_cell.sv
// One slot of the sorted insertion row.
module mf_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 8
) (
	input  logic                             clk,
	input  mf_pkg::mf_cell_ctl_t             ctl,
	input  logic [CNT_W-1:0]                 cnt,
	input  logic signed [mf_pkg::DATA_W-1:0] prev_val,
	input  logic                             prev_gt,
	input  logic signed [mf_pkg::DATA_W-1:0] next_val,
	output logic signed [mf_pkg::DATA_W-1:0] val,
	output logic                             gt
);

	logic signed [mf_pkg::DATA_W-1:0] val_q;
	logic                             occ;

	assign occ = cnt > CNT_W'(IDX);
	// empty slots act as +infinity; equal values stay put
	assign gt  = !occ || ($signed(val_q) > $signed(ctl.ins_val));
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && gt) begin
			val_q <= prev_gt ? prev_val : ctl.ins_val;
		end else if (ctl.shl) begin
			val_q <= next_val;
		end
	end

endmodule

### hw/rtl/median_finder_core.sv
// Median finder top level: insertion cell row, drain sequencer and result register.
// A value without last_item is absorbed at one request per cycle while busy is low.
// A request with last_item holds busy while the left shifts of the cell row bring the
// middle element to slot 0; done is high in the cycle right after the last busy cycle.
// The receiver cannot stall the result.
// Reset clears the count, drop flag, sequencer and strobe; cell contents are not reset.
module median_finder_core #(
	parameter int MAX_VALUES = mf_pkg::MAX_VALUES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  mf_pkg::mf_req_t req,
	output logic            done,
	output mf_pkg::mf_res_t res
);

	localparam int CNT_W = $clog2(MAX_VALUES + 1);

	mf_pkg::mf_state_t    state_q, state_nx;
	mf_pkg::mf_cell_ctl_t ctl;

	logic [CNT_W-1:0] cnt_q;      // values kept in the current set
	logic [CNT_W-1:0] n_q;        // set size latched at the end of the set
	logic [CNT_W-1:0] shift_q;    // left shifts still to go
	logic             drop_q;
	logic             done_q;
	mf_pkg::mf_res_t  res_q;

	logic             accept;
	logic             full;
	logic [CNT_W-1:0] n_new;
	logic             fin;        // last drain cycle: result is read from slots 0 and 1

	logic signed [mf_pkg::DATA_W-1:0] cell_val [MAX_VALUES];
	logic                             cell_gt  [MAX_VALUES];

	logic signed [mf_pkg::DATA_W:0]   pair_sum;
	logic signed [mf_pkg::DATA_W-1:0] med;

	assign busy   = (state_q == mf_pkg::MF_DRAIN);
	assign accept = start && !busy;
	assign full   = (cnt_q == CNT_W'(MAX_VALUES));
	// a dropped value still closes the set
	assign n_new  = full ? cnt_q : cnt_q + CNT_W'(1);
	assign fin    = busy && (shift_q == '0);

	// ---------------------------------------------------------------
	// Sequencer: fill takes requests, drain walks the row left.
	// ---------------------------------------------------------------
	always_comb begin
		state_nx    = state_q;
		ctl.ins     = 1'b0;
		ctl.shl     = 1'b0;
		ctl.ins_val = req.sample;
		unique case (state_q)
			mf_pkg::MF_IDLE: begin
				ctl.ins = accept && !full;
				if (accept && req.last_item) begin
					state_nx = mf_pkg::MF_DRAIN;
				end
			end
			mf_pkg::MF_DRAIN: begin
				ctl.shl = (shift_q != '0);
				if (shift_q == '0) begin
					state_nx = mf_pkg::MF_IDLE;
				end
			end
			default: state_nx = mf_pkg::MF_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mf_pkg::MF_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// ---------------------------------------------------------------
	// Count, drop flag and drain counter.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			n_q     <= '0;
			shift_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= fin;
			if (accept) begin
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (req.last_item) begin
					n_q     <= n_new;
					// odd n: mid shifts; even n: mid-1 shifts
					shift_q <= (n_new - CNT_W'(1)) >> 1;
				end
			end else if (busy && shift_q != '0) begin
				shift_q <= shift_q - CNT_W'(1);
			end
			if (fin) begin
				cnt_q  <= '0;
				drop_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Cell row. Each cell compares the broadcast value with its own
	// entry and takes its left neighbor or the new value (insert), or its right neighbor (drain).
	// ---------------------------------------------------------------
	for (genvar i = 0; i < MAX_VALUES; i++) begin : g_cell
		logic signed [mf_pkg::DATA_W-1:0] pv;
		logic signed [mf_pkg::DATA_W-1:0] nv;
		logic                             pg;
		if (i == 0) begin : g_first
			assign pv = '0;
			assign pg = 1'b0;
		end else begin : g_mid
			assign pv = cell_val[i-1];
			assign pg = cell_gt[i-1];
		end
		if (i == MAX_VALUES - 1) begin : g_end
			assign nv = '0;
		end else begin : g_inner
			assign nv = cell_val[i+1];
		end
		mf_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.cnt      (cnt_q),
			.prev_val (pv),
			.prev_gt  (pg),
			.next_val (nv),
			.val      (cell_val[i]),
			.gt       (cell_gt[i])
		);
	end

	// ---------------------------------------------------------------
	// Result: odd count takes slot 0, even count floor-averages slots 0
	// and 1 in 33 bits.
	// ---------------------------------------------------------------
	assign pair_sum = {cell_val[0][mf_pkg::DATA_W-1], cell_val[0]}
	                + {cell_val[1][mf_pkg::DATA_W-1], cell_val[1]};
	assign med      = n_q[0] ? cell_val[0] : pair_sum[mf_pkg::DATA_W:1];

	always_ff @(posedge clk) begin
		if (fin) begin
			res_q.median_value <= med;
			res_q.set_size     <= mf_pkg::SIZE_W'(n_q);
			res_q.overflowed   <= drop_q;
		end
	end

	assign done = done_q;
	assign res  = res_q;

	// ---------------------------------------------------------------
	// Checks.
	// ---------------------------------------------------------------
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while draining");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.last_item |=> busy)
		else $error("set end did not start drain");

	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !done)
		else $error("result right after an accepted request");

	a_drain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy && shift_q != '0 |=> busy)
		else $error("drain ended with shifts pending");

endmodule

### bench/mf_checker.sv
// Median finder checker: tracks each set, predicts its median and compares results.
module mf_checker
	import mf_pkg::*;
#(
	parameter int MAX_VALUES = MAX_VALUES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  mf_req_t req,
	input  logic    done,
	input  mf_res_t res,
	output int      fail_count,
	output int      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [DATA_W-1:0] sample_t;

	sample_t kept_vals[$];   // current set, ascending
	logic    drop_seen;
	mf_res_t median_q[$];    // medians still owed by the block
	mf_res_t oldest_median;

	function automatic mf_res_t median_of_kept();
		int                     n;
		logic signed [DATA_W:0] pair_sum;
		mf_res_t                r;
		n = kept_vals.size();
		if (n % 2) begin
			r.median_value = kept_vals[n/2];
		end else begin
			// 33-bit sum, then arithmetic halving (floor)
			pair_sum       = kept_vals[n/2-1] + kept_vals[n/2];
			r.median_value = pair_sum[DATA_W:1];
		end
		r.set_size   = SIZE_W'(n);
		r.overflowed = drop_seen;
		return r;
	endfunction

	task automatic absorb_request(input mf_req_t rq);
		int pos;
		if (kept_vals.size() < MAX_VALUES) begin
			// equal values go after the ones already kept
			pos = kept_vals.size();
			while (pos > 0 && kept_vals[pos-1] > rq.sample)
				pos--;
			kept_vals.insert(pos, rq.sample);
		end else begin
			drop_seen = 1'b1;
		end
		if (rq.last_item) begin
			median_q.insert(median_q.size(), median_of_kept());
			kept_vals.delete();
			drop_seen = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_vals.delete();
			median_q.delete();
			drop_seen  = 1'b0;
			fail_count = 0;
			pending    = 0;
		end else begin
			// a strobe at this edge can never belong to a request accepted at it
			if (done) begin
				if (median_q.size() == 0) begin
					$display("%0t: unexpected result, median_value %0d set_size %0d overflowed %0b",
						$time, res.median_value, res.set_size, res.overflowed);
					fail_count++;
				end else begin
					oldest_median = median_q.pop_front();
					if (res.median_value !== oldest_median.median_value) begin
						$display("%0t: median_value expected %0d, got %0d",
							$time, oldest_median.median_value, res.median_value);
						fail_count++;
					end
					if (res.set_size !== oldest_median.set_size) begin
						$display("%0t: set_size expected %0d, got %0d",
							$time, oldest_median.set_size, res.set_size);
						fail_count++;
					end
					if (res.overflowed !== oldest_median.overflowed) begin
						$display("%0t: overflowed expected %0b, got %0b",
							$time, oldest_median.overflowed, res.overflowed);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				absorb_request(req);
			pending = median_q.size();
		end
	end

endmodule

### bench/tb_top.sv
// Median finder testbench top: clock, reset, request stimulus and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mf_pkg::*;

	localparam int STORE_DEPTH  = MAX_VALUES_DEF;
	localparam int RANDOM_ITEMS = 550;
	// covers the worst drain plus the strobe, with margin
	localparam int DRAIN_CYCLES = STORE_DEPTH / 2 + 16;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int GAP_PERCENT  = 11;

	typedef logic signed [DATA_W-1:0] sample_t;

	// how the values of one random set are drawn
	typedef enum logic [1:0] {
		VAL_FULL,     // any 32-bit pattern
		VAL_NARROW,   // small integers, many ties and near-ties
		VAL_EXTREME,  // range edges and zero
		VAL_REPEAT    // a handful of Q16.16 whole numbers
	} value_style_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	mf_req_t req;
	logic    done;
	mf_res_t res;

	int fail_count;
	int pending;
	int cycle_count;
	int sent_count;
	int set_count;
	int overflow_sets;
	int random_goal;
	int set_size;
	logic no_gaps;

	median_finder_core #(
		.MAX_VALUES(STORE_DEPTH)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.res   (res)
	);

	mf_checker #(
		.MAX_VALUES(STORE_DEPTH)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.res       (res),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung drain or a lost strobe ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** median_finder_core: FAILED **");
			$finish;
		end
	end

	function automatic sample_t pick_value(input value_style_t style);
		sample_t v;
		case (style)
			VAL_FULL: begin
				v = $urandom;
			end
			VAL_NARROW: begin
				v = int'($urandom_range(0, 20)) - 10;
			end
			VAL_EXTREME: begin
				case ($urandom_range(0, 4))
					0:       v = 32'sh7FFF_FFFF;
					1:       v = 32'sh8000_0000;
					2:       v = 32'sh7FFF_FFFE;
					3:       v = 32'sh8000_0001;
					default: v = '0;
				endcase
			end
			default: begin
				// -2.0 .. 2.0 in Q16.16
				v = (int'($urandom_range(0, 4)) - 2) * 65536;
			end
		endcase
		return v;
	endfunction

	// Present one request and hold it until the block takes it.
	// Exactly one assignment to start per edge, so back-to-back requests keep it high.
	task automatic put_request(input sample_t value, input logic last);
		int gap;
		gap = 0;
		if (!no_gaps && $urandom_range(0, 99) < GAP_PERCENT)
			gap = 1;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		req.sample    <= value;
		req.last_item <= last;
		// accepted at the first edge where busy is low
		do
			@(posedge clk);
		while (busy);
		sent_count++;
		// long back-to-back stretch in the middle of the run
		no_gaps = (sent_count >= 250 && sent_count < 400);
	endtask

	task automatic run_set(input int size, input value_style_t style);
		for (int i = 0; i < size; i++)
			put_request(pick_value(style), i == size - 1);
		set_count++;
		if (size > STORE_DEPTH)
			overflow_sets++;
	endtask

	initial begin
		cycle_count   = 0;
		sent_count    = 0;
		set_count     = 0;
		overflow_sets = 0;
		no_gaps       = 1'b0;
		start  <= 1'b0;
		req    <= '0;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets: single values at the range edges and zero
		put_request(32'sh7FFF_FFFF, 1'b1);
		put_request(32'sh8000_0000, 1'b1);
		put_request(32'sh0000_0000, 1'b1);
		// even pairs: largest sum, smallest sum, edges cancelling to -1
		put_request(32'sh7FFF_FFFF, 1'b0);
		put_request(32'sh7FFF_FFFF, 1'b1);
		put_request(32'sh8000_0000, 1'b0);
		put_request(32'sh8000_0000, 1'b1);
		put_request(32'sh7FFF_FFFF, 1'b0);
		put_request(32'sh8000_0000, 1'b1);
		// floor of odd sums, negative and positive
		put_request(-32'sd1, 1'b0);
		put_request(32'sd0, 1'b1);
		put_request(32'sd1, 1'b0);
		put_request(32'sd2, 1'b1);
		// ties, descending order, mixed-sign ties in an even set
		put_request(32'sh0005_0000, 1'b0);
		put_request(32'sh0005_0000, 1'b0);
		put_request(32'sh0005_0000, 1'b1);
		put_request(32'sd3, 1'b0);
		put_request(32'sd2, 1'b0);
		put_request(32'sd1, 1'b1);
		put_request(32'sh0007_0000, 1'b0);
		put_request(-32'sh0007_0000, 1'b0);
		put_request(32'sh0007_0000, 1'b0);
		put_request(-32'sh0007_0000, 1'b1);

		// Random sets: mostly short, one filling the store exactly, one running past it
		// so that dropped values, including a dropped last value, are exercised.
		random_goal = sent_count + RANDOM_ITEMS;
		for (int s = 0; sent_count < random_goal; s++) begin
			if (s == 6)
				set_size = STORE_DEPTH;
			else if (s == 14)
				set_size = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 4);
			else
				set_size = $urandom_range(1, 10);
			run_set(set_size, value_style_t'($urandom_range(0, 3)));
		end
		start <= 1'b0;

		// Let every owed median arrive, then watch for strays.
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests in %0d sets; %0d sets ran past the %0d-entry store.",
			sent_count, set_count, overflow_sets, STORE_DEPTH);
		$display("Values covered range edges, ties, narrow ranges and full 32-bit random.");
		if (fail_count == 0 && pending == 0) begin
			$display("** median_finder_core: PASSED **");
		end else begin
			$display("** median_finder_core: FAILED **");
		end
		$finish;
	end

endmodule
